// ===== src/gpm_pkg.sv =====
// ----------------------------------------------------------------------------
// gpm_pkg - shared definitions for the GF(2^8) polynomial MAC
// Field arithmetic helper, sizes and register indexes.
// ----------------------------------------------------------------------------
package gpm_pkg;

  localparam int unsigned MAX_KEYS = 4;
  localparam int unsigned KEY_REGS = 4;
  localparam int unsigned SLOT_W   = 2;
  localparam int unsigned IDX_W    = 3;
  localparam logic [8:0]  GF_POLY  = 9'h11B;

  // register indexes
  localparam logic [IDX_W-1:0] REG_KEY0   = 3'd0;
  localparam logic [IDX_W-1:0] REG_KEY1   = 3'd1;
  localparam logic [IDX_W-1:0] REG_KEY2   = 3'd2;
  localparam logic [IDX_W-1:0] REG_KEY3   = 3'd3;
  localparam logic [IDX_W-1:0] REG_ACTIVE = 3'd4;

  // highest usable slot count
  localparam int unsigned KEY_LIMIT = (MAX_KEYS < KEY_REGS) ? MAX_KEYS : KEY_REGS;

  typedef logic [7:0] gf_t;

  // shift-and-add multiply, reduced by x^8+x^4+x^3+x+1
  function automatic gf_t gf_mul(input gf_t x, input gf_t y);
    logic [8:0] sh;
    gf_t        acc;
    acc = '0;
    sh  = {1'b0, x};
    for (int i = 0; i < 8; i++) begin
      if (y[i]) acc = acc ^ sh[7:0];
      sh = {sh[7:0], 1'b0};
      if (sh[8]) sh = sh ^ GF_POLY;
    end
    return acc;
  endfunction

endpackage

// ===== src/gf256_polynomial_mac_top.sv =====
// A block-end byte waits in the input register until it retires, which captures
// the tags into the tag buffer and sets busy_q, so the first tag becomes valid.
// Throughput is one byte per cycle unless a block end waits for the last block's
// tags to drain; tags leave by the single output port, overlapped with new bytes.
// Reset (rst_ni low, async): keys and powers 0, tags 0, active_keys 1,
// no pending transactions.
// ----------------------------------------------------------------------------
// gf256_polynomial_mac_top - GF(2^8) polynomial evaluation MAC, up to 4 keys
// Per byte: tag[s] ^= byte * power[s]; power[s] *= key[s]. At block end one
// tag per active key (at least one) is streamed out, the last marked with tlast.
// ----------------------------------------------------------------------------
module gf256_polynomial_mac_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input stream
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [7:0]                  s_axis_tdata_i,   // [7:0] data_byte
  input  logic                        s_axis_tlast_i,   // block_end
  // result stream
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [7:0]                  m_axis_tdata_o,   // [7:0] tag_byte
  output logic [gpm_pkg::SLOT_W-1:0]  m_axis_tuser_o,   // [1:0] key_slot
  output logic                        m_axis_tlast_o,   // final_tag
  // configuration writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [gpm_pkg::IDX_W-1:0]   cfg_index_i,
  input  logic [7:0]                  cfg_data_i
);

  localparam int unsigned NK = gpm_pkg::KEY_REGS;

  // configuration
  gpm_pkg::gf_t key_q [NK];
  logic [2:0]   active_q;

  // input register
  logic         in_valid_q;
  gpm_pkg::gf_t in_byte_q;
  logic         in_last_q;

  // running state per slot
  gpm_pkg::gf_t tag_q   [NK];
  gpm_pkg::gf_t power_q [NK];
  gpm_pkg::gf_t tag_d   [NK];
  gpm_pkg::gf_t power_d [NK];

  // tag buffer for emission
  gpm_pkg::gf_t               tag_buf_q [NK];
  logic                       busy_q;
  logic [gpm_pkg::SLOT_W-1:0] ptr_q;
  logic [gpm_pkg::SLOT_W-1:0] last_idx_q;
  logic [gpm_pkg::SLOT_W-1:0] last_idx_d;

  logic out_fire, last_pop, stage_go, in_fire, cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;
  assign last_pop = out_fire && m_axis_tlast_o;

  // the staged byte retires unless it closes a block while tags still drain
  assign stage_go        = in_valid_q && (!in_last_q || !busy_q || last_pop);
  assign s_axis_tready_o = !in_valid_q || stage_go;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // field update for every slot in parallel, inactive ones included
  always_comb begin
    for (int s = 0; s < NK; s++) begin
      tag_d[s]   = tag_q[s] ^ gpm_pkg::gf_mul(in_byte_q, power_q[s]);
      power_d[s] = gpm_pkg::gf_mul(power_q[s], key_q[s]);
    end
  end

  // tags per block: zero counts as one, large values saturate
  always_comb begin
    if (active_q == 3'd0) begin
      last_idx_d = '0;
    end else if ({29'd0, active_q} > gpm_pkg::KEY_LIMIT) begin
      last_idx_d = gpm_pkg::SLOT_W'(gpm_pkg::KEY_LIMIT - 1);
    end else begin
      last_idx_d = gpm_pkg::SLOT_W'(active_q - 3'd1);
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // configuration registers and running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 3'd1;
      for (int s = 0; s < NK; s++) begin
        key_q[s]   <= '0;
        tag_q[s]   <= '0;
        power_q[s] <= '0;
      end
    end else begin
      if (stage_go) begin
        for (int s = 0; s < NK; s++) begin
          if (in_last_q) begin
            tag_q[s]   <= '0;
            power_q[s] <= key_q[s];
          end else begin
            tag_q[s]   <= tag_d[s];
            power_q[s] <= power_d[s];
          end
        end
      end
      // users write only while idle (not enforced); key writes restart slot powers
      if (cfg_fire) begin
        case (cfg_index_i)
          gpm_pkg::REG_KEY0: begin
            key_q[0]   <= cfg_data_i;
            power_q[0] <= cfg_data_i;
          end
          gpm_pkg::REG_KEY1: begin
            key_q[1]   <= cfg_data_i;
            power_q[1] <= cfg_data_i;
          end
          gpm_pkg::REG_KEY2: begin
            key_q[2]   <= cfg_data_i;
            power_q[2] <= cfg_data_i;
          end
          gpm_pkg::REG_KEY3: begin
            key_q[3]   <= cfg_data_i;
            power_q[3] <= cfg_data_i;
          end
          gpm_pkg::REG_ACTIVE: active_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
    end
  end

  // emission control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      ptr_q      <= '0;
      last_idx_q <= '0;
    end else begin
      if (stage_go && in_last_q) begin
        busy_q     <= 1'b1;
        ptr_q      <= '0;
        last_idx_q <= last_idx_d;
      end else if (last_pop) begin
        busy_q <= 1'b0;
      end else if (out_fire) begin
        ptr_q <= ptr_q + 1'b1;
      end
    end
  end

  // finished tags, captured at block end
  always_ff @(posedge clk_i) begin
    if (stage_go && in_last_q) begin
      for (int s = 0; s < NK; s++) tag_buf_q[s] <= tag_d[s];
    end
  end

  assign m_axis_tvalid_o = busy_q;
  assign m_axis_tdata_o  = tag_buf_q[ptr_q];
  assign m_axis_tuser_o  = ptr_q;
  assign m_axis_tlast_o  = (ptr_q == last_idx_q);

`ifndef ASSERT_OFF
  // read pointer never passes the last active slot
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (ptr_q <= last_idx_q))
    else $error("emission pointer beyond last active slot");

  // a non-final tag is followed by the next slot's tag
  a_slot_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !m_axis_tlast_o) |=>
      (m_axis_tvalid_o && (m_axis_tuser_o == $past(m_axis_tuser_o) + 2'd1)))
    else $error("tag slot sequence broken");

  // a block end waiting on the buffer is held, not dropped
  a_hold_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && in_last_q && busy_q && !last_pop) |=>
      (in_valid_q && in_last_q && $stable(in_byte_q)))
    else $error("pending block end lost");

  // a new burst always starts at slot zero
  a_burst_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_go && in_last_q) |=> (busy_q && (ptr_q == '0)))
    else $error("tag burst did not start at slot zero");
`endif

endmodule

// ===== tb/sv/tb_gf256_polynomial_mac_top.sv =====
// ----------------------------------------------------------------------------
// tb_gf256_polynomial_mac_top - self-checking bench for the GF(2^8) MAC
// Streams data bytes in blocks and predicts every tag with a local copy of
// the key, power and tag state. Directed cases come first, then random blocks
// with random key and slot-count changes between them, a long sink stall,
// and a closing stretch at full rate.
// ----------------------------------------------------------------------------
module tb_gf256_polynomial_mac_top;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;    // settle margin after the last tag
  localparam int unsigned HOLD_CYCLES  = 80;   // long sink stall
  localparam int unsigned MAX_REPORTS  = 10;

  // one finished tag as it should leave the block
  typedef struct packed {
    logic [7:0]                 tag;
    logic [gpm_pkg::SLOT_W-1:0] slot;
    logic                       fin;
  } tag_rec_t;

  logic clk_i;
  logic rst_n = 1'b0;

  // stimulus side, all known from time zero
  logic                        s_tvalid  = 1'b0;
  logic [7:0]                  s_tdata   = '0;
  logic                        s_tlast   = 1'b0;
  logic                        m_tready  = 1'b0;
  logic                        cfg_valid = 1'b0;
  logic [gpm_pkg::IDX_W-1:0]   cfg_index = '0;
  logic [7:0]                  cfg_data  = '0;

  logic                        s_tready;
  logic                        m_tvalid;
  logic [7:0]                  m_tdata;
  logic [gpm_pkg::SLOT_W-1:0]  m_tuser;
  logic                        m_tlast;
  logic                        cfg_ready;

  // local copy of the MAC state and its registers
  logic [7:0] key_m [gpm_pkg::KEY_REGS];
  logic [7:0] pow_m [gpm_pkg::KEY_REGS];
  logic [7:0] tag_m [gpm_pkg::KEY_REGS];
  logic [2:0] active_m;

  tag_rec_t    expected_tags[$];
  int unsigned tag_errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_cnt  = 0;
  bit          idle_en    = 1'b1;   // random bubbles on both sides
  bit          hold_req   = 1'b0;   // ask the sink for one long stall

  gf256_polynomial_mac_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Horner-style multiply, MSB of a first; each step doubles then adds b.
  function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 7; i >= 0; i--) begin
      p = {p[6:0], 1'b0} ^ (p[7] ? gpm_pkg::GF_POLY[7:0] : 8'h00);
      if (a[i]) p = p ^ b;
    end
    return p;
  endfunction

  function automatic void clear_state();
    for (int s = 0; s < gpm_pkg::KEY_REGS; s++) begin
      key_m[s] = '0;
      pow_m[s] = '0;
      tag_m[s] = '0;
    end
    active_m = 3'd1;
  endfunction

  // Fold one accepted byte into every slot; on block end queue the tags.
  function automatic void absorb_byte(input logic [7:0] d, input logic eob);
    int unsigned n;
    tag_rec_t    rec;
    for (int s = 0; s < gpm_pkg::KEY_REGS; s++) begin
      tag_m[s] = tag_m[s] ^ gf_times(d, pow_m[s]);   // old power first
      pow_m[s] = gf_times(pow_m[s], key_m[s]);
    end
    if (eob) begin
      // zero counts as one slot, oversized counts saturate
      n = active_m;
      if (n < 1) n = 1;
      if (n > gpm_pkg::KEY_LIMIT) n = gpm_pkg::KEY_LIMIT;
      for (int s = 0; s < n; s++) begin
        rec.tag       = tag_m[s];
        rec.slot      = gpm_pkg::SLOT_W'(s);
        rec.fin       = (s == n - 1);
        expected_tags = {expected_tags, rec};
      end
      for (int s = 0; s < gpm_pkg::KEY_REGS; s++) begin
        tag_m[s] = '0;
        pow_m[s] = key_m[s];
      end
    end
  endfunction

  initial clear_state();

  // input monitor: every accepted byte goes through the predictor
  always @(posedge clk_i) begin
    if (rst_n && s_tvalid && s_tready) absorb_byte(s_tdata, s_tlast);
  end

  // ---------------------------------------------------------------------------
  // Result checker: oldest expectation against each accepted tag
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tag_rec_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (expected_tags.size() == 0) begin
        if (tag_errors < MAX_REPORTS)
          $display("unexpected tag: tag=%02h slot=%0d fin=%0b", m_tdata, m_tuser, m_tlast);
        tag_errors++;
      end else begin
        want = expected_tags.pop_front();
        if (m_tdata !== want.tag || m_tuser !== want.slot || m_tlast !== want.fin) begin
          if (tag_errors < MAX_REPORTS)
            $display("tag mismatch: exp tag=%02h slot=%0d fin=%0b, got tag=%02h slot=%0d fin=%0b",
                     want.tag, want.slot, want.fin, m_tdata, m_tuser, m_tlast);
          tag_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sink ready: random bubbles, plus one long stall on request
  // ---------------------------------------------------------------------------
  initial begin : sink_ready
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        m_tready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Offer one byte and return in the step of its acceptance. tvalid is left high
  // so back-to-back bytes stream at full rate while ready; wait_drain lowers it.
  task automatic send_byte(input logic [7:0] d, input logic eob);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= eob;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Stop offering, wait for every queued tag, then let the pipe settle.
  // The first edge lets the monitor queue the tags of the last accepted byte.
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_tags.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One register write; only called with the block idle.
  task automatic cfg_write(input logic [gpm_pkg::IDX_W-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    if (idx <= gpm_pkg::REG_KEY3) begin
      key_m[idx[gpm_pkg::SLOT_W-1:0]] = data;   // key write reloads its power only
      pow_m[idx[gpm_pkg::SLOT_W-1:0]] = data;
    end else if (idx == gpm_pkg::REG_ACTIVE) begin
      active_m = data[2:0];
    end
    @(posedge clk_i);                     // cfg_valid low before the next write
  endtask

  // bytes skewed toward the extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_block(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_byte(pick_byte(), i == len - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // After reset all keys and powers are zero and one slot is active.
  task automatic test_reset_defaults();
    send_byte(8'hA5, 1'b1);
    wait_drain();
  endtask

  // Extreme keys in all four slots; zero padding must not move a tag.
  task automatic test_key_extremes();
    cfg_write(gpm_pkg::REG_KEY0, 8'hFF);
    cfg_write(gpm_pkg::REG_KEY1, 8'h01);
    cfg_write(gpm_pkg::REG_KEY2, 8'h80);
    cfg_write(gpm_pkg::REG_KEY3, 8'h00);
    cfg_write(gpm_pkg::REG_ACTIVE, 8'd4);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_drain();
  endtask

  // Slot count sweep: zero, in range, above the limit, and upper data bits.
  task automatic test_active_range();
    logic [7:0] counts [9];
    counts = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd7, 8'h08, 8'hFC};
    foreach (counts[i]) begin
      cfg_write(gpm_pkg::REG_ACTIVE, counts[i]);
      send_byte(8'hC3 ^ 8'(i), 1'b1);
      wait_drain();
    end
  endtask

  // Writes to indexes past the last register must change nothing.
  task automatic test_unknown_index();
    for (int i = gpm_pkg::REG_ACTIVE + 1; i < (1 << gpm_pkg::IDX_W); i++)
      cfg_write(gpm_pkg::IDX_W'(i), 8'hFF);
    send_byte(8'hFF, 1'b1);
    wait_drain();
  endtask

  // Pause mid-block, change keys and raise the slot count, then finish.
  task automatic test_midblock_update();
    cfg_write(gpm_pkg::REG_ACTIVE, 8'd1);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    wait_drain();
    cfg_write(gpm_pkg::REG_KEY0, 8'h02);
    cfg_write(gpm_pkg::REG_KEY2, 8'h35);
    cfg_write(gpm_pkg::REG_ACTIVE, 8'd4);
    send_byte(8'h33, 1'b1);
    wait_drain();
  endtask

  // Random blocks; between some of them a random register gets random data.
  task automatic test_random_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      send_block($urandom_range(1, 8));
      if ($urandom_range(0, 3) == 0) begin
        wait_drain();
        cfg_write(gpm_pkg::IDX_W'($urandom), 8'($urandom));
      end
    end
    wait_drain();
  endtask

  // Long sink stall with one-byte blocks of four tags each; the input backs up.
  task automatic test_backpressure();
    for (int s = 0; s < gpm_pkg::KEY_REGS; s++)
      cfg_write(gpm_pkg::REG_KEY0 + gpm_pkg::IDX_W'(s), 8'($urandom));
    cfg_write(gpm_pkg::REG_ACTIVE, 8'd4);
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++) send_byte(8'($urandom), 1'b1);
    wait_drain();
  endtask

  // Closing stretch with no bubbles on either side.
  task automatic test_full_rate();
    idle_en = 1'b0;
    cfg_write(gpm_pkg::REG_ACTIVE, 8'($urandom_range(1, 4)));
    test_random_traffic(25);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_key_extremes();
    test_active_range();
    test_unknown_index();
    test_midblock_update();
    test_random_traffic(45);
    test_backpressure();
    test_full_rate();

    wait_drain();
    if (tag_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/gpm_pkg.sv
src/gf256_polynomial_mac_top.sv
tb/sv/tb_gf256_polynomial_mac_top.sv
